### rtl/core/sstf_pkg.sv
// Shared types and constants for the SSTF disk scheduler.
// No dependencies.
`default_nettype none
package sstf_pkg;
   localparam int MAX_REQ = 64;
   localparam int IDX_W   = $clog2(MAX_REQ);
   localparam int CNT_W   = $clog2(MAX_REQ + 1);
   localparam int TRK_W   = 8;
   localparam int TOT_W   = 14;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_SERVED   = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef enum logic [1:0] {FSM_IDLE, FSM_SCAN, FSM_SEND} fsm_type;

   typedef struct packed {
      logic             shift;
      logic             clear_all;
      logic             load;
      logic             kill;
      logic [IDX_W-1:0] sel;
      logic [TRK_W-1:0] load_track;
   } cell_ctrl_type;
endpackage
`default_nettype wire

### rtl/core/sstf_cell.sv
// One slot of the rotating request ring: track and valid bit.
// Depends on sstf_pkg.
`default_nettype none
module sstf_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sstf_pkg::cell_ctrl_type    ctrl,
   input  wire logic [sstf_pkg::IDX_W-1:0] my_idx,
   input  wire logic [sstf_pkg::TRK_W-1:0] nb_track,
   input  wire logic                       nb_valid,
   output logic      [sstf_pkg::TRK_W-1:0] track,
   output logic                            valid
);
   logic [sstf_pkg::TRK_W-1:0] track_ff, track_in;
   logic                       valid_ff, valid_in;
   logic                       hit;

   assign hit = (ctrl.sel == my_idx);

   always_comb begin
      track_in = track_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         track_in = nb_track;
         valid_in = nb_valid;
      end else if (ctrl.load && hit) begin
         track_in = ctrl.load_track;
         valid_in = 1'b1;
      end else if (ctrl.kill && hit) begin
         valid_in = 1'b0;
      end
      if (ctrl.clear_all) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      track_ff <= track_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   assign track = track_ff;
   assign valid = valid_ff;
endmodule
`default_nettype wire

### rtl/core/sstf_disk_scheduler.sv
// Top level of the SSTF disk scheduler: ring of request cells plus control.
// Depends on sstf_pkg and sstf_cell.
`default_nettype none
// Channel | dir | tdata                                   | tuser      | tlast
// req     | in  | [7:0] track, [15:8] start_position      | op         | -
// rsp     | out | [7:0] served_track, [15:8] seek_distance,| status[1:0]| last
//         |     | [29:16] total_seek, [31:30] zero        |            |
// Load and empty-run beats go straight to the result register on acceptance.
// Each served result costs a scan (one full rotation of the cell ring past the
// single comparator) plus a send cycle; no req is taken until the run ends.
// Synchronous active-high reset clears valid bits, count and control.
// A stalled rsp holds the sender; req is taken only when idle and rsp slot free.
module sstf_disk_scheduler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] track, [15:8] start_position
   input  wire logic        req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [7:0] track, [15:8] seek, [29:16] total
   output logic      [1:0]  rsp_tuser,   // status
   output logic             rsp_tlast
);
   localparam int N  = sstf_pkg::MAX_REQ;
   localparam int IW = sstf_pkg::IDX_W;
   localparam int CW = sstf_pkg::CNT_W;
   localparam int TW = sstf_pkg::TRK_W;
   localparam int SW = sstf_pkg::TOT_W;

   sstf_pkg::fsm_type       state_ff, state_in;
   sstf_pkg::cell_ctrl_type ctrl;

   logic [TW-1:0] c_track [N];
   logic          c_valid [N];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic [TW-1:0] head_ff, head_in;
   logic [SW-1:0] total_ff, total_in;
   logic          found_ff, found_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [TW-1:0] best_trk_ff, best_trk_in;
   logic [TW-1:0] best_dst_ff, best_dst_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_stat_ff, rsp_stat_in;
   logic [TW-1:0] rsp_trk_ff, rsp_trk_in;
   logic [TW-1:0] rsp_dst_ff, rsp_dst_in;
   logic [SW-1:0] rsp_tot_ff, rsp_tot_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          slot_free, req_acc, scan_end, last_pick;
   logic [TW-1:0] cur_dist;
   logic [TW-1:0] req_track, req_start;

   assign req_track = req_tdata[7:0];
   assign req_start = req_tdata[15:8];
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign req_acc   = req_tvalid && req_tready;
   assign scan_end  = (scan_ff == IW'(N - 1));
   assign last_pick = (remain_ff == CW'(1));

   // cell ring: cell i takes its neighbor i+1 on a shift, last wraps to 0
   for (genvar i = 0; i < N; i++) begin : g_cell
      sstf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .my_idx   (IW'(i)),
         .nb_track (c_track[(i + 1) % N]),
         .nb_valid (c_valid[(i + 1) % N]),
         .track    (c_track[i]),
         .valid    (c_valid[i])
      );
   end

   // distance of the entry passing the comparator at cell 0
   assign cur_dist = (c_track[0] > head_ff) ? (c_track[0] - head_ff)
                                            : (head_ff - c_track[0]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sstf_pkg::FSM_IDLE:
            if (req_acc && req_tuser == sstf_pkg::OP_RUN && count_ff != '0)
               state_in = sstf_pkg::FSM_SCAN;
         sstf_pkg::FSM_SCAN:
            if (scan_end) state_in = sstf_pkg::FSM_SEND;
         sstf_pkg::FSM_SEND:
            if (slot_free) state_in = last_pick ? sstf_pkg::FSM_IDLE : sstf_pkg::FSM_SCAN;
         default: state_in = sstf_pkg::FSM_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready   = (state_ff == sstf_pkg::FSM_IDLE) && slot_free;
      ctrl         = '0;
      ctrl.sel     = (state_ff == sstf_pkg::FSM_IDLE) ? count_ff[IW-1:0] : best_idx_ff;
      ctrl.load_track = req_track;
      count_in     = count_ff;
      remain_in    = remain_ff;
      scan_in      = scan_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_trk_in  = best_trk_ff;
      best_dst_in  = best_dst_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_trk_in   = rsp_trk_ff;
      rsp_dst_in   = rsp_dst_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         sstf_pkg::FSM_IDLE: begin
            if (req_acc) begin
               rsp_valid_in = 1'b1;
               rsp_trk_in   = '0;
               rsp_dst_in   = '0;
               rsp_tot_in   = '0;
               rsp_last_in  = 1'b1;
               if (req_tuser == sstf_pkg::OP_LOAD) begin
                  if (count_ff >= CW'(N)) begin
                     rsp_stat_in = sstf_pkg::ST_FULL;
                  end else begin
                     rsp_stat_in = sstf_pkg::ST_ACCEPTED;
                     ctrl.load   = 1'b1;
                     count_in    = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_stat_in = sstf_pkg::ST_EMPTY;
               end else begin
                  rsp_valid_in = rsp_valid_ff && !rsp_tready;
                  head_in      = req_start;
                  total_in     = '0;
                  remain_in    = count_ff;
                  scan_in      = '0;
                  found_in     = 1'b0;
               end
            end
         end
         sstf_pkg::FSM_SCAN: begin
            ctrl.shift = 1'b1;
            scan_in    = scan_ff + IW'(1);
            // strict less-than keeps the earliest slot on ties
            if (c_valid[0] && (!found_ff || cur_dist < best_dst_ff)) begin
               found_in    = 1'b1;
               best_idx_in = scan_ff;
               best_trk_in = c_track[0];
               best_dst_in = cur_dist;
            end
         end
         sstf_pkg::FSM_SEND: begin
            if (slot_free) begin
               ctrl.kill    = 1'b1;
               total_in     = total_ff + SW'(best_dst_ff);
               head_in      = best_trk_ff;
               remain_in    = remain_ff - CW'(1);
               scan_in      = '0;
               found_in     = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_stat_in  = sstf_pkg::ST_SERVED;
               rsp_trk_in   = best_trk_ff;
               rsp_dst_in   = best_dst_ff;
               rsp_tot_in   = total_ff + SW'(best_dst_ff);
               rsp_last_in  = last_pick;
               if (last_pick) begin
                  ctrl.clear_all = 1'b1;
                  count_in       = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sstf_pkg::FSM_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         scan_ff      <= scan_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_ff     <= head_in;
      total_ff    <= total_in;
      best_idx_ff <= best_idx_in;
      best_trk_ff <= best_trk_in;
      best_dst_ff <= best_dst_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_trk_ff  <= rsp_trk_in;
      rsp_dst_ff  <= rsp_dst_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_tot_ff, rsp_dst_ff, rsp_trk_ff};

   // fill count never passes the store depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(N)) else $error("pending count overflow");

   // a send always has a pick from the preceding scan
   a_send_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == sstf_pkg::FSM_SEND |-> found_ff) else $error("send without pick");

   // the final served beat empties the store
   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sstf_pkg::FSM_SEND && slot_free && last_pick) |=> count_ff == '0)
      else $error("store not cleared after run");
endmodule
`default_nettype wire
